// ----- hw/rtl/obb_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, sequencer program and sine table generator for the
// oriented-box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int CHUNK_BITS = 32;   // multiplier B-operand slice
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int NPROG = 56;
   localparam int PC_W = 6;

   localparam logic [2:0] SEP_NONE = 3'd0;

   typedef enum logic [2:0] {
      S_IDLE, S_TRIG, S_RESOLVE, S_ISSUE, S_WAIT, S_POST, S_DONE
   } state_type;

   typedef enum logic [1:0] {T_SA, T_CA, T_SB, T_CB} tsel_type;

   typedef enum logic [4:0] {
      B_DXA, B_DYA, B_DXB, B_DYB,
      B_HA, B_WA, B_HB, B_WB,
      B_E0, B_E1, B_E2, B_E3, B_E4, B_E5, B_E6, B_E7,
      B_D0, B_D1
   } bsel_type;

   typedef enum logic [2:0] {P_NONE, P_D0, P_D1, P_EDGE, P_EXT, P_TEST} post_type;

   typedef struct packed {
      tsel_type   tsel;
      logic       neg;
      bsel_type   bsel;
      post_type   post;
      logic [2:0] edst;
   } instr_type;

   typedef struct packed {
      logic start;
      logic neg;
      logic load;
   } mac_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_sts_type;

   function automatic instr_type mk(tsel_type t, logic n, bsel_type b, post_type p,
                                    logic [2:0] e);
      instr_type r;
      r.tsel = t;
      r.neg  = n;
      r.bsel = b;
      r.post = p;
      r.edst = e;
      return r;
   endfunction

   // Elaboration only: Taylor series in Q30, rounded to fb fraction bits.
   // Term n is divided by (2n)(2n+1), written out for n = 1..10.
   function automatic longint unsigned quarter_sine(int k, int ab, int fb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (longint'(k) * HALF_PI_Q30) >> (ab - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;    sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;   sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;   sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd272;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd342;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd420;  sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      return (longint'(sum) + (64'd1 << (29 - fb))) >> (30 - fb);
   endfunction

   // Centre difference, edges, then four axes, each over all edge terms and
   // the centre-difference terms.
   localparam instr_type PROGRAM [NPROG] = '{
      mk(T_CA, 1'b0, B_DXA, P_NONE, 3'd0), mk(T_SA, 1'b1, B_DYA, P_NONE, 3'd0),
      mk(T_CB, 1'b1, B_DXB, P_NONE, 3'd0), mk(T_SB, 1'b0, B_DYB, P_D0,   3'd0),
      mk(T_CA, 1'b0, B_DYA, P_NONE, 3'd0), mk(T_SA, 1'b0, B_DXA, P_NONE, 3'd0),
      mk(T_CB, 1'b1, B_DYB, P_NONE, 3'd0), mk(T_SB, 1'b1, B_DXB, P_D1,   3'd0),
      mk(T_SA, 1'b1, B_HA, P_EDGE, 3'd0), mk(T_CA, 1'b0, B_HA, P_EDGE, 3'd1),
      mk(T_CA, 1'b0, B_WA, P_EDGE, 3'd2), mk(T_SA, 1'b0, B_WA, P_EDGE, 3'd3),
      mk(T_SB, 1'b1, B_HB, P_EDGE, 3'd4), mk(T_CB, 1'b0, B_HB, P_EDGE, 3'd5),
      mk(T_CB, 1'b0, B_WB, P_EDGE, 3'd6), mk(T_SB, 1'b0, B_WB, P_EDGE, 3'd7),
      // first box y axis (-sa, ca)
      mk(T_SA, 1'b1, B_E0, P_NONE, 3'd0), mk(T_CA, 1'b0, B_E1, P_EXT, 3'd0),
      mk(T_SA, 1'b1, B_E2, P_NONE, 3'd0), mk(T_CA, 1'b0, B_E3, P_EXT, 3'd0),
      mk(T_SA, 1'b1, B_E4, P_NONE, 3'd0), mk(T_CA, 1'b0, B_E5, P_EXT, 3'd0),
      mk(T_SA, 1'b1, B_E6, P_NONE, 3'd0), mk(T_CA, 1'b0, B_E7, P_EXT, 3'd0),
      mk(T_SA, 1'b1, B_D0, P_NONE, 3'd0), mk(T_CA, 1'b0, B_D1, P_TEST, 3'd0),
      // first box x axis (ca, sa)
      mk(T_CA, 1'b0, B_E0, P_NONE, 3'd0), mk(T_SA, 1'b0, B_E1, P_EXT, 3'd0),
      mk(T_CA, 1'b0, B_E2, P_NONE, 3'd0), mk(T_SA, 1'b0, B_E3, P_EXT, 3'd0),
      mk(T_CA, 1'b0, B_E4, P_NONE, 3'd0), mk(T_SA, 1'b0, B_E5, P_EXT, 3'd0),
      mk(T_CA, 1'b0, B_E6, P_NONE, 3'd0), mk(T_SA, 1'b0, B_E7, P_EXT, 3'd0),
      mk(T_CA, 1'b0, B_D0, P_NONE, 3'd0), mk(T_SA, 1'b0, B_D1, P_TEST, 3'd0),
      // second box y axis (-sb, cb)
      mk(T_SB, 1'b1, B_E0, P_NONE, 3'd0), mk(T_CB, 1'b0, B_E1, P_EXT, 3'd0),
      mk(T_SB, 1'b1, B_E2, P_NONE, 3'd0), mk(T_CB, 1'b0, B_E3, P_EXT, 3'd0),
      mk(T_SB, 1'b1, B_E4, P_NONE, 3'd0), mk(T_CB, 1'b0, B_E5, P_EXT, 3'd0),
      mk(T_SB, 1'b1, B_E6, P_NONE, 3'd0), mk(T_CB, 1'b0, B_E7, P_EXT, 3'd0),
      mk(T_SB, 1'b1, B_D0, P_NONE, 3'd0), mk(T_CB, 1'b0, B_D1, P_TEST, 3'd0),
      // second box x axis (cb, sb)
      mk(T_CB, 1'b0, B_E0, P_NONE, 3'd0), mk(T_SB, 1'b0, B_E1, P_EXT, 3'd0),
      mk(T_CB, 1'b0, B_E2, P_NONE, 3'd0), mk(T_SB, 1'b0, B_E3, P_EXT, 3'd0),
      mk(T_CB, 1'b0, B_E4, P_NONE, 3'd0), mk(T_SB, 1'b0, B_E5, P_EXT, 3'd0),
      mk(T_CB, 1'b0, B_E6, P_NONE, 3'd0), mk(T_SB, 1'b0, B_E7, P_EXT, 3'd0),
      mk(T_CB, 1'b0, B_D0, P_NONE, 3'd0), mk(T_SB, 1'b0, B_D1, P_TEST, 3'd0)
   };

endpackage

// ----- hw/rtl/obb_trig_rom.sv -----
// ----------------------------------------------------------------------------
// obb_trig_rom
// Quarter-wave sine table, Q1.F, registered read.
// ----------------------------------------------------------------------------
module obb_trig_rom import obb_pkg::*; #(
   parameter int ANGLE_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                      clock,
   input  logic [ANGLE_BITS-2:0]     rd_addr,
   output logic [TRIG_FRAC_BITS:0]   rd_data
);

   localparam int QSZ   = 1 << (ANGLE_BITS - 2);
   localparam int NADDR = 1 << (ANGLE_BITS - 1);
   localparam int TV_W  = TRIG_FRAC_BITS + 1;

   logic [TV_W-1:0] tab [NADDR];

   // entries past a quarter turn are never addressed
   for (genvar g = 0; g < NADDR; g++) begin : g_tab
      assign tab[g] = (g <= QSZ) ? TV_W'(quarter_sine(g, ANGLE_BITS, TRIG_FRAC_BITS))
                                 : '0;
   end

   always_ff @(posedge clock) begin
      rd_data <= tab[rd_addr];
   end

endmodule

// ----- hw/rtl/obb_mac.sv -----
// ----------------------------------------------------------------------------
// obb_mac
// Shared multiply-accumulate: trig operand times a wide operand, one
// 32-bit slice per multiply, accumulated with the slice weight.
// ----------------------------------------------------------------------------
module obb_mac import obb_pkg::*; #(
   parameter int TW    = 17,
   parameter int NCH   = 2,
   parameter int ACC_W = 82
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mac_cmd_type                         cmd,
   input  logic signed [TW-1:0]                a,
   input  logic signed [NCH*CHUNK_BITS-1:0]    b,
   input  logic signed [ACC_W-1:0]             load_value,
   output logic signed [ACC_W-1:0]             acc,
   output mac_sts_type                         sts
);

   localparam int KW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int MUL_W = TW + CHUNK_BITS + 1;

   logic                      active_ff;
   logic                      phase_ff;     // 0 multiply, 1 add
   logic                      done_ff;
   logic                      neg_ff;
   logic [KW-1:0]             k_ff;
   logic signed [MUL_W-1:0]   mul_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   logic [CHUNK_BITS-1:0]     chunk;
   logic signed [CHUNK_BITS:0] op;
   logic signed [MUL_W-1:0]   mul_in;
   logic signed [ACC_W-1:0]   term;
   logic                      last_chunk;

   always_comb begin
      last_chunk = (k_ff == KW'(NCH - 1));
      chunk      = b[k_ff*CHUNK_BITS +: CHUNK_BITS];
      // only the top slice carries the sign
      op         = last_chunk ? $signed({chunk[CHUNK_BITS-1], chunk})
                              : $signed({1'b0, chunk});
      mul_in     = a * op;
      term       = ACC_W'(mul_ff) <<< (k_ff * CHUNK_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= 1'b0;
         done_ff   <= 1'b0;
         k_ff      <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            active_ff <= 1'b1;
            phase_ff  <= 1'b0;
            k_ff      <= '0;
         end else if (active_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               if (last_chunk) begin
                  active_ff <= 1'b0;
                  done_ff   <= 1'b1;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) neg_ff <= cmd.neg;
      if (active_ff && !phase_ff) mul_ff <= mul_in;
      if (cmd.load) begin
         acc_ff <= load_value;
      end else if (active_ff && phase_ff) begin
         acc_ff <= neg_ff ? acc_ff - term : acc_ff + term;
      end
   end

   assign acc      = acc_ff;
   assign sts.busy = active_ff;
   assign sts.done = done_ff;

endmodule

// ----- hw/rtl/obb_overlap_test.sv -----
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating-axis overlap test of two rotated rectangles, run as a small
// program on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | ports  | direction | beat
//  --------+--------+-----------+------------------------------------------
//  request | req_*  | in        | one box; second_of_pair picks store/test
//  result  | rsp_*  | out       | overlap flag and first separating axis
//
//  A store beat is taken while idle. A test beat holds req_stall until all
//  axes are checked, or ends early at the first separating axis. NCH is the
//  number of 32-bit slices of the centre difference, 2 at default widths;
//  the shared multiplier works through them one slice at a time.
//  Reset is synchronous; the held box resets to zero.
//  req_stall is high while a test runs; a result waiting on rsp_stall does
//  not block the next request beat.
// ----------------------------------------------------------------------------
module obb_overlap_test import obb_pkg::*; #(
   parameter int COORD_BITS     = 16,
   parameter int ANGLE_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic [14:0]                   req_box_width,
   input  logic [14:0]                   req_box_height,
   input  logic [ANGLE_BITS-1:0]         req_box_angle,
   input  logic signed [COORD_BITS-1:0]  req_pivot_x,
   input  logic signed [COORD_BITS-1:0]  req_pivot_y,
   input  logic                          req_second_of_pair,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_overlap,
   output logic [2:0]                    rsp_separating_axis
);

   // widths of the fixed-point datapath
   localparam int F      = TRIG_FRAC_BITS;
   localparam int M      = (COORD_BITS > 15) ? COORD_BITS : 15;
   localparam int TW     = F + 2;                 // signed sin/cos
   localparam int TV_W   = F + 1;                 // table value
   localparam int DIM_W  = M + 3;                 // w - 2*pivot
   localparam int DW     = F + M + 6;             // doubled centre difference
   localparam int EDGE_W = F + 18;                // dim * trig
   localparam int NCH    = (DW + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PADW   = NCH * CHUNK_BITS;
   localparam int ACC_A  = 2 * F + M + 10;
   localparam int ACC_B  = F + 3 + PADW;
   localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
   localparam int RA_W   = ANGLE_BITS - 1;
   localparam int QSZ    = 1 << (ANGLE_BITS - 2);

   state_type                    state_ff, state_in;
   logic [2:0]                   cnt_ff, cnt_in;
   logic [PC_W-1:0]              pc_ff, pc_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [2:0]                   sep_ff, sep_in;

   // held (first) box
   logic signed [COORD_BITS-1:0] held_pos_x_ff, held_pos_y_ff;
   logic signed [COORD_BITS-1:0] held_pivot_x_ff, held_pivot_y_ff;
   logic [14:0]                  held_width_ff, held_height_ff;
   logic [ANGLE_BITS-1:0]        held_angle_ff;
   // box under test
   logic signed [COORD_BITS-1:0] cur_pos_x_ff, cur_pos_y_ff;
   logic signed [COORD_BITS-1:0] cur_pivot_x_ff, cur_pivot_y_ff;
   logic [14:0]                  cur_width_ff, cur_height_ff;
   logic [ANGLE_BITS-1:0]        cur_angle_ff;

   logic [TV_W-1:0]              t_ff [4];     // tk_a, tr_a, tk_b, tr_b
   logic signed [TW-1:0]         sa_ff, ca_ff, sb_ff, cb_ff;
   logic signed [DW-1:0]         d0_ff, d1_ff;
   logic signed [EDGE_W-1:0]     edge_ff [8];
   logic [ACC_W-1:0]             ext_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_overlap_ff;
   logic [2:0]                   rsp_sep_ff;

   // strobes
   logic held_we, cur_we, t_we, trig_we, d0_we, d1_we, edge_we;
   logic ext_clr, ext_add, rsp_load;

   instr_type                    ins;
   mac_cmd_type                  mac_cmd;
   mac_sts_type                  mac_sts;
   logic signed [TW-1:0]         a_val;
   logic signed [PADW-1:0]       b_val;
   logic signed [ACC_W-1:0]      acc;
   logic signed [ACC_W-1:0]      load_value;
   logic [ACC_W-1:0]             acc_abs;
   logic [RA_W-1:0]              rom_addr;
   logic [TV_W-1:0]              rom_data;
   logic [1:0]                   t_idx;

   logic signed [DIM_W-1:0]      dxa, dya, dxb, dyb;
   logic signed [COORD_BITS:0]   ddx, ddy;
   logic signed [ACC_W-1:0]      posx_term, posy_term;
   logic [2*TW-1:0]              sc_a, sc_b;

   assign ins = PROGRAM[pc_ff];

   // quadrant folding of the quarter-wave values into sin/cos
   function automatic logic [2*TW-1:0] fold(logic [1:0] q, logic [TV_W-1:0] tk,
                                            logic [TV_W-1:0] tr);
      logic signed [TW-1:0] pk;
      logic signed [TW-1:0] pr;
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] c;
      pk = $signed({1'b0, tk});
      pr = $signed({1'b0, tr});
      unique case (q)
         2'd0: begin s = pk;  c = pr;  end
         2'd1: begin s = pr;  c = -pk; end
         2'd2: begin s = -pk; c = -pr; end
         default: begin s = -pr; c = pk; end
      endcase
      return {s, c};
   endfunction

   obb_trig_rom #(
      .ANGLE_BITS     (ANGLE_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   obb_mac #(
      .TW    (TW),
      .NCH   (NCH),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mac_cmd),
      .a          (a_val),
      .b          (b_val),
      .load_value (load_value),
      .acc        (acc),
      .sts        (mac_sts)
   );

   // --- operand preparation ------------------------------------------------
   always_comb begin
      dxa = DIM_W'($signed({1'b0, held_width_ff}))  - (DIM_W'(held_pivot_x_ff) <<< 1);
      dya = DIM_W'($signed({1'b0, held_height_ff})) - (DIM_W'(held_pivot_y_ff) <<< 1);
      dxb = DIM_W'($signed({1'b0, cur_width_ff}))   - (DIM_W'(cur_pivot_x_ff) <<< 1);
      dyb = DIM_W'($signed({1'b0, cur_height_ff}))  - (DIM_W'(cur_pivot_y_ff) <<< 1);
      ddx = (COORD_BITS+1)'(held_pos_x_ff) - (COORD_BITS+1)'(cur_pos_x_ff);
      ddy = (COORD_BITS+1)'(held_pos_y_ff) - (COORD_BITS+1)'(cur_pos_y_ff);
      // anchor difference of the doubled centres, scaled to Q.F
      posx_term = ACC_W'(ddx) <<< (F + 1);
      posy_term = ACC_W'(ddy) <<< (F + 1);
      sc_a = fold(held_angle_ff[ANGLE_BITS-1 -: 2], t_ff[0], t_ff[1]);
      sc_b = fold(cur_angle_ff[ANGLE_BITS-1 -: 2],  t_ff[2], t_ff[3]);
      acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
   end

   // table reads: k and Q-k of each box
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: rom_addr = {1'b0, held_angle_ff[ANGLE_BITS-3:0]};
         2'd1: rom_addr = RA_W'(QSZ) - {1'b0, held_angle_ff[ANGLE_BITS-3:0]};
         2'd2: rom_addr = {1'b0, cur_angle_ff[ANGLE_BITS-3:0]};
         default: rom_addr = RA_W'(QSZ) - {1'b0, cur_angle_ff[ANGLE_BITS-3:0]};
      endcase
      t_idx = 2'(cnt_ff - 3'd1);
   end

   always_comb begin
      unique case (ins.tsel)
         T_SA: a_val = sa_ff;
         T_CA: a_val = ca_ff;
         T_SB: a_val = sb_ff;
         default: a_val = cb_ff;
      endcase
   end

   always_comb begin
      unique case (ins.bsel)
         B_DXA: b_val = PADW'(dxa);
         B_DYA: b_val = PADW'(dya);
         B_DXB: b_val = PADW'(dxb);
         B_DYB: b_val = PADW'(dyb);
         B_HA:  b_val = PADW'($signed({1'b0, held_height_ff}));
         B_WA:  b_val = PADW'($signed({1'b0, held_width_ff}));
         B_HB:  b_val = PADW'($signed({1'b0, cur_height_ff}));
         B_WB:  b_val = PADW'($signed({1'b0, cur_width_ff}));
         B_E0:  b_val = PADW'(edge_ff[0]);
         B_E1:  b_val = PADW'(edge_ff[1]);
         B_E2:  b_val = PADW'(edge_ff[2]);
         B_E3:  b_val = PADW'(edge_ff[3]);
         B_E4:  b_val = PADW'(edge_ff[4]);
         B_E5:  b_val = PADW'(edge_ff[5]);
         B_E6:  b_val = PADW'(edge_ff[6]);
         B_E7:  b_val = PADW'(edge_ff[7]);
         B_D0:  b_val = PADW'(d0_ff);
         B_D1:  b_val = PADW'(d1_ff);
         default: b_val = '0;
      endcase
   end

   // accumulator preload: x anchor term before the x centre difference,
   // y anchor term right after it, zero otherwise
   always_comb begin
      if (state_ff == S_RESOLVE)  load_value = posx_term;
      else if (ins.post == P_D0)  load_value = posy_term;
      else                        load_value = '0;
   end

   // --- sequencer ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pc_in    = pc_ff;
      axis_in  = axis_ff;
      sep_in   = sep_ff;
      mac_cmd  = '0;
      held_we  = 1'b0;
      cur_we   = 1'b0;
      t_we     = 1'b0;
      trig_we  = 1'b0;
      d0_we    = 1'b0;
      d1_we    = 1'b0;
      edge_we  = 1'b0;
      ext_clr  = 1'b0;
      ext_add  = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_second_of_pair) begin
                  cur_we   = 1'b1;
                  cnt_in   = '0;
                  state_in = S_TRIG;
               end else begin
                  held_we = 1'b1;
               end
            end
         end
         S_TRIG: begin
            // registered table read: capture on counts 1..4
            t_we = (cnt_ff != 3'd0);
            if (cnt_ff == 3'd4) state_in = S_RESOLVE;
            else                cnt_in   = cnt_ff + 3'd1;
         end
         S_RESOLVE: begin
            trig_we      = 1'b1;
            mac_cmd.load = 1'b1;
            ext_clr      = 1'b1;
            pc_in        = '0;
            axis_in      = '0;
            state_in     = S_ISSUE;
         end
         S_ISSUE: begin
            mac_cmd.start = 1'b1;
            mac_cmd.neg   = ins.neg;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (mac_sts.done) begin
               if (ins.post == P_NONE) begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = S_ISSUE;
               end else begin
                  state_in = S_POST;
               end
            end
         end
         S_POST: begin
            pc_in        = pc_ff + 1'b1;
            mac_cmd.load = 1'b1;
            state_in     = S_ISSUE;
            unique case (ins.post)
               P_D0:   d0_we   = 1'b1;
               P_D1:   d1_we   = 1'b1;
               P_EDGE: edge_we = 1'b1;
               P_EXT:  ext_add = 1'b1;
               P_TEST: begin
                  if (acc_abs > ext_ff) begin
                     sep_in   = 3'(axis_ff) + 3'd1;
                     state_in = S_DONE;
                  end else if (axis_ff == 2'd3) begin
                     sep_in   = SEP_NONE;
                     state_in = S_DONE;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                     ext_clr = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cnt_ff          <= '0;
         pc_ff           <= '0;
         axis_ff         <= '0;
         sep_ff          <= SEP_NONE;
         rsp_valid_ff    <= 1'b0;
         held_pos_x_ff   <= '0;
         held_pos_y_ff   <= '0;
         held_width_ff   <= '0;
         held_height_ff  <= '0;
         held_angle_ff   <= '0;
         held_pivot_x_ff <= '0;
         held_pivot_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pc_ff    <= pc_in;
         axis_ff  <= axis_in;
         sep_ff   <= sep_in;
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (held_we) begin
            held_pos_x_ff   <= req_pos_x;
            held_pos_y_ff   <= req_pos_y;
            held_width_ff   <= req_box_width;
            held_height_ff  <= req_box_height;
            held_angle_ff   <= req_box_angle;
            held_pivot_x_ff <= req_pivot_x;
            held_pivot_y_ff <= req_pivot_y;
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_pos_x_ff   <= req_pos_x;
         cur_pos_y_ff   <= req_pos_y;
         cur_width_ff   <= req_box_width;
         cur_height_ff  <= req_box_height;
         cur_angle_ff   <= req_box_angle;
         cur_pivot_x_ff <= req_pivot_x;
         cur_pivot_y_ff <= req_pivot_y;
      end
      if (t_we) t_ff[t_idx] <= rom_data;
      if (trig_we) begin
         {sa_ff, ca_ff} <= sc_a;
         {sb_ff, cb_ff} <= sc_b;
      end
      if (d0_we)   d0_ff <= DW'(acc);
      if (d1_we)   d1_ff <= DW'(acc);
      if (edge_we) edge_ff[ins.edst] <= EDGE_W'(acc);
      if (ext_clr)      ext_ff <= '0;
      else if (ext_add) ext_ff <= ext_ff + acc_abs;
      if (rsp_load) begin
         rsp_overlap_ff <= (sep_ff == SEP_NONE);
         rsp_sep_ff     <= sep_ff;
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_overlap         = rsp_overlap_ff;
   assign rsp_separating_axis = rsp_sep_ff;

   // --- assertions ---------------------------------------------------------
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while a test runs");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_overlap == (rsp_separating_axis == SEP_NONE)))
      else $error("overlap flag disagrees with separating axis");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_separating_axis <= 3'd4))
      else $error("separating axis out of range");

   a_issue_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> !mac_sts.busy)
      else $error("product issued while the multiplier is busy");

endmodule

// ----- bench/obb_overlap_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_overlap_checker
// Watches both channels of the box overlap block. It keeps its own copy of
// the stored box and works out the overlap verdict of every test beat. It
// compares each result beat in order and counts the mismatches.
// ----------------------------------------------------------------------------
module obb_overlap_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [14:0]        req_box_width,
   input  logic [14:0]        req_box_height,
   input  logic [11:0]        req_box_angle,
   input  logic signed [15:0] req_pivot_x,
   input  logic signed [15:0] req_pivot_y,
   input  logic               req_second_of_pair,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_overlap,
   input  logic [2:0]         rsp_separating_axis,
   output int                 mismatches,
   output int                 verdicts_pending,
   output int                 verdicts_checked
);

   localparam int QUARTER = 1024;
   localparam longint ONE = 64'sd32768;

   typedef struct {
      longint px, py, w, h, vx, vy;
      int     ang;
   } box_t;

   typedef struct {
      logic       overlap;
      logic [2:0] axis;
   } verdict_t;

   longint   sine_rom [0:QUARTER];
   box_t     held_box;
   verdict_t verdict_q [$];

   // Quarter-wave sine in Q1.15, Taylor series evaluated in Q30.
   function automatic longint sine_entry(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (longint'(k) * 64'd1686629713) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      return (acc + 64'd16384) >> 15;
   endfunction

   initial begin
      for (int k = 0; k <= QUARTER; k++) sine_rom[k] = sine_entry(k);
   end

   function automatic void angle_trig(int ang, output longint s, output longint c);
      int     k;
      longint tk;
      longint tr;
      k  = ang % QUARTER;
      tk = sine_rom[k];
      tr = sine_rom[QUARTER - k];
      case (ang / QUARTER)
         0: begin s = tk;  c = tr;  end
         1: begin s = tr;  c = -tk; end
         2: begin s = -tk; c = -tr; end
         default: begin s = -tr; c = tk; end
      endcase
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Returns 0 when no axis separates, else the first separating axis.
   function automatic logic [2:0] first_separating_axis(box_t a, box_t b);
      longint sa, ca, sb, cb, dxa, dya, dxb, dyb;
      longint dif [2];
      longint ax [4][2];
      longint ed [4][2];
      longint extent;
      angle_trig(a.ang, sa, ca);
      angle_trig(b.ang, sb, cb);
      dxa = a.w - 2 * a.vx;
      dya = a.h - 2 * a.vy;
      dxb = b.w - 2 * b.vx;
      dyb = b.h - 2 * b.vy;
      dif[0] = (ca * dxa - sa * dya + a.px * 2 * ONE) - (cb * dxb - sb * dyb + b.px * 2 * ONE);
      dif[1] = (ca * dya + sa * dxa + a.py * 2 * ONE) - (cb * dyb + sb * dxb + b.py * 2 * ONE);
      ax[0] = '{-sa, ca}; ax[1] = '{ca, sa};
      ax[2] = '{-sb, cb}; ax[3] = '{cb, sb};
      ed[0] = '{-a.h * sa, a.h * ca}; ed[1] = '{a.w * ca, a.w * sa};
      ed[2] = '{-b.h * sb, b.h * cb}; ed[3] = '{b.w * cb, b.w * sb};
      for (int i = 0; i < 4; i++) begin
         extent = 0;
         for (int j = 0; j < 4; j++)
            extent += mag(ax[i][0] * ed[j][0] + ax[i][1] * ed[j][1]);
         if (mag(ax[i][0] * dif[0] + ax[i][1] * dif[1]) > extent)
            return 3'(i + 1);
      end
      return 3'd0;
   endfunction

   always @(posedge clock) begin
      box_t     nb;
      verdict_t exp_v;
      if (reset) begin
         held_box         = '{0, 0, 0, 0, 0, 0, 0};
         verdict_q        = {};
         mismatches       = 0;
         verdicts_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            nb = '{req_pos_x, req_pos_y, req_box_width, req_box_height,
                   req_pivot_x, req_pivot_y, req_box_angle};
            if (!req_second_of_pair) begin
               held_box = nb;
            end else begin
               exp_v.axis    = first_separating_axis(held_box, nb);
               exp_v.overlap = (exp_v.axis == 3'd0);
               verdict_q.push_back(exp_v);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result beat overlap=%0b axis=%0d", $realtime,
                           rsp_overlap, rsp_separating_axis);
            end else begin
               exp_v = verdict_q.pop_front();
               verdicts_checked++;
               if (rsp_overlap !== exp_v.overlap || rsp_separating_axis !== exp_v.axis) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch overlap exp %0b got %0b, axis exp %0d got %0d",
                              $realtime, exp_v.overlap, rsp_overlap, exp_v.axis,
                              rsp_separating_axis);
               end
            end
         end
      end
      verdicts_pending = verdict_q.size();
   end

endmodule

// ----- bench/tb_obb_overlap_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_obb_overlap_test
// Stimulus and verdict for the box overlap block. A directed set of boxes
// comes first. Then come random store/test sequences under three idling
// mixes, one long result hold-off and one drain pause. The checker does the
// prediction and the comparison.
// ----------------------------------------------------------------------------
module tb_obb_overlap_test;
   import obb_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic [14:0]        req_box_width;
   logic [14:0]        req_box_height;
   logic [11:0]        req_box_angle;
   logic signed [15:0] req_pivot_x;
   logic signed [15:0] req_pivot_y;
   logic               req_second_of_pair;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_overlap;
   logic [2:0]         rsp_separating_axis;

   int mismatches;
   int verdicts_pending;
   int verdicts_checked;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_req;
   int beats_sent;
   int n_tests;
   int wait_cycles;

   obb_overlap_test u_dut (.*);

   obb_overlap_checker u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_pos_x, .req_pos_y,
      .req_box_width, .req_box_height, .req_box_angle, .req_pivot_x,
      .req_pivot_y, .req_second_of_pair, .rsp_valid, .rsp_stall, .rsp_overlap,
      .rsp_separating_axis, .mismatches, .verdicts_pending, .verdicts_checked
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, with wide margin over the whole run.
   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stall, plus a long hold-off when the sender asks.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 800;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   // One beat: hold the payload until accepted, then possibly go idle.
   task automatic send_box(int px, int py, int w, int h, int ang, int vx, int vy,
                           bit test);
      req_valid          = 1'b1;
      req_pos_x          = 16'(px);
      req_pos_y          = 16'(py);
      req_box_width      = 15'(w);
      req_box_height     = 15'(h);
      req_box_angle      = 12'(ang);
      req_pivot_x        = 16'(vx);
      req_pivot_y        = 16'(vy);
      req_second_of_pair = test;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (test) n_tests++;
      @(negedge clock);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // Mostly small boxes near each other so all verdicts occur; some full range.
   task automatic send_random_box(bit test);
      int span;
      int sz;
      if ($urandom_range(9) == 0) begin
         send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, test);
      end else begin
         span = $urandom_range(1) ? 64 : 600;
         sz   = $urandom_range(1) ? 40 : 400;
         send_box($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                  $urandom_range(sz), $urandom_range(sz), $urandom_range(4095),
                  $urandom_range(2 * sz) - sz, $urandom_range(2 * sz) - sz, test);
      end
   endtask

   // Sender goes quiet until every expected result has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   task automatic random_pairs(int beats);
      int start;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         send_random_box(1'b0);
         repeat ($urandom_range(1, 3)) send_random_box(1'b1);
         if ($urandom_range(19) == 0) send_random_box($urandom_range(1));
      end
   endtask

   initial begin
      req_valid          = 1'b0;
      req_pos_x          = '0;
      req_pos_y          = '0;
      req_box_width      = '0;
      req_box_height     = '0;
      req_box_angle      = '0;
      req_pivot_x        = '0;
      req_pivot_y        = '0;
      req_second_of_pair = 1'b0;
      tx_idle_pct        = 0;
      rx_idle_pct        = 0;
      hold_req           = 0;
      beats_sent         = 0;
      n_tests            = 0;
      reset              = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: test against the zero box held from reset, then extremes.
      send_box(0, 0, 0, 0, 0, 0, 0, 1'b1);
      send_box(100, 0, 10, 10, 0, 0, 0, 1'b1);
      send_box(0, 0, 20, 10, 0, 0, 0, 1'b0);
      send_box(20, 0, 20, 10, 0, 0, 0, 1'b1);     // touching edge: overlap
      send_box(21, 0, 20, 10, 0, 0, 0, 1'b1);     // just apart on x
      send_box(0, 11, 20, 10, 0, 0, 0, 1'b1);     // just apart on y
      send_box(0, 0, 0, 0, 512, 0, 0, 1'b1);      // degenerate box, same corner
      send_box(0, 0, 20, 10, 1024, 0, 0, 1'b1);
      send_box(0, 0, 20, 10, 2048, 0, 0, 1'b1);
      send_box(0, 0, 20, 10, 3072, 0, 0, 1'b1);
      send_box(0, 0, 20, 10, 4095, 10, 5, 1'b1);
      send_box(0, 0, 400, 20, 512, 200, 10, 1'b0);
      send_box(300, 300, 20, 20, 0, 0, 0, 1'b1);  // clear of rotated first box
      send_box(230, -20, 400, 20, 3584, 200, 10, 1'b1);
      send_box(-32768, -32768, 32767, 32767, 4095, -32768, -32768, 1'b0);
      send_box(32767, 32767, 32767, 32767, 0, 32767, 32767, 1'b1);
      send_box(-32768, 32767, 0, 32767, 2047, 32767, -32768, 1'b1);
      send_box(32767, -32768, 32767, 0, 1, -1, -1, 1'b1);
      send_box(5, 5, 0, 0, 0, 0, 0, 1'b0);
      send_box(5, 5, 0, 0, 777, 0, 0, 1'b1);      // equal centres
      drain();

      // Random phases under the three idling mixes.
      tx_idle_pct = 21;
      rx_idle_pct = 50;
      random_pairs(600);
      tx_idle_pct = 50;
      rx_idle_pct = 21;
      hold_req++;                                 // long hold-off, sender keeps going
      random_pairs(600);
      drain();                                    // sender pauses until all results in
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_pairs(660);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (verdicts_pending != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (400) @(negedge clock);

      $display("Covered %0d box beats, %0d of them tests; %0d verdicts compared.",
               beats_sent, n_tests, verdicts_checked);
      $display("Idling mixes 21/50, 50/21 and none, with one long result hold-off.");
      if (mismatches == 0 && verdicts_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/obb_pkg.sv
hw/rtl/obb_trig_rom.sv
hw/rtl/obb_mac.sv
hw/rtl/obb_overlap_test.sv
bench/obb_overlap_checker.sv
bench/tb_obb_overlap_test.sv
